FILE: hw/rtl/mtt_pkg.sv
// Package for the markup text tokenizer: position width, character classes,
// token kinds and the packed word types of both channels. No dependencies.
`default_nettype none

package mtt_pkg;

    localparam int POSITION_BITS = 16;

    typedef logic [POSITION_BITS-1:0] t_pos;

    typedef enum logic [2:0] {
        CLS_NULL      = 3'd0,
        CLS_SPACE     = 3'd1,
        CLS_ALNUM     = 3'd2,
        CLS_PUNCT     = 3'd3,
        CLS_EOL       = 3'd4,
        CLS_TAG_END   = 3'd5,
        CLS_TAG_BEGIN = 3'd6
    } t_class;

    typedef enum logic [1:0] {
        KIND_TEXT  = 2'd0,
        KIND_SPACE = 2'd1,
        KIND_TAG   = 2'd2
    } t_kind;

    localparam logic [15:0] CH_NUL   = 16'h0000;
    localparam logic [15:0] CH_LF    = 16'h000A;
    localparam logic [15:0] CH_SPACE = 16'h0020;
    localparam logic [15:0] CH_QUOTE = 16'h0022;
    localparam logic [15:0] CH_LT    = 16'h003C;
    localparam logic [15:0] CH_GT    = 16'h003E;

    typedef struct packed {
        logic [15:0] ch;
        logic        start_of_text;
    } t_in;

    typedef struct packed {
        logic        token_valid;
        logic [1:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic        tag_open;
        logic        tag_close;
    } t_out;

    typedef struct packed {
        logic   inside_tag;
        logic   inside_quotes;
        t_class previous_class;
    } t_ctx;

    typedef struct packed {
        t_class cls;
        logic   toggle_quotes;
    } t_cls_res;

endpackage

`default_nettype wire

FILE: hw/rtl/mtt_classify.sv
// Character classifier of the markup text tokenizer.
// Depends on mtt_pkg for the class codes and character constants.
`default_nettype none

module mtt_classify (
    input  wire logic [15:0]      i_ch,
    input  wire mtt_pkg::t_ctx    i_ctx,
    output mtt_pkg::t_cls_res     o_res
);

    logic is_alnum;
    logic is_punct;

    always_comb begin
        is_alnum = (i_ch >= 16'd48 && i_ch <= 16'd57) ||
                   (i_ch >= 16'd65 && i_ch <= 16'd90) ||
                   (i_ch >= 16'd97 && i_ch <= 16'd122);
        is_punct = (i_ch >= 16'd33 && i_ch <= 16'd47) ||
                   (i_ch >= 16'd58 && i_ch <= 16'd64) ||
                   (i_ch >= 16'd91 && i_ch <= 16'd96) ||
                   (i_ch >= 16'd123 && i_ch <= 16'd126);
    end

    always_comb begin
        o_res.cls           = mtt_pkg::CLS_NULL;
        o_res.toggle_quotes = 1'b0;
        priority if (i_ch == mtt_pkg::CH_GT) begin
            o_res.cls = mtt_pkg::CLS_TAG_END;
        end else if (i_ch == mtt_pkg::CH_LT) begin
            o_res.cls = mtt_pkg::CLS_TAG_BEGIN;
        end else if (i_ctx.inside_tag && i_ch == mtt_pkg::CH_QUOTE) begin
            o_res.toggle_quotes = 1'b1;
        end else if (i_ch > 16'd127 || is_alnum) begin
            o_res.cls = mtt_pkg::CLS_ALNUM;
        end else if (is_punct) begin
            o_res.cls = i_ctx.inside_tag ? mtt_pkg::CLS_PUNCT : mtt_pkg::CLS_ALNUM;
        end else if (i_ch == mtt_pkg::CH_SPACE) begin
            o_res.cls = i_ctx.inside_quotes ? i_ctx.previous_class : mtt_pkg::CLS_SPACE;
        end else if (i_ch == mtt_pkg::CH_NUL || i_ch == mtt_pkg::CH_LF) begin
            o_res.cls = mtt_pkg::CLS_EOL;
        end else begin
            o_res.cls = mtt_pkg::CLS_NULL;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/markup_text_tokenizer.sv
// Top level of the markup text tokenizer: run tracking and the result register.
// Depends on mtt_pkg and mtt_classify.
`default_nettype none

// One character word is taken per cycle while o_in_ready is high, and it yields
// exactly one result word in the next cycle; the input is ready whenever the
// result register is empty or being read in the same cycle, so a full stream
// runs at one character per clock. The rate is set by the single
// classify-and-compare stage between the input port and the result register.
module markup_text_tokenizer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire mtt_pkg::t_in  i_in_word,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output mtt_pkg::t_out      o_out_word
);

    logic            r_inside_tag;
    logic            r_inside_quotes;
    mtt_pkg::t_class r_previous_class;
    mtt_pkg::t_pos   r_run_start;
    mtt_pkg::t_pos   r_position;
    logic            r_out_valid;
    mtt_pkg::t_out   r_out_word;

    logic            n_inside_tag;
    logic            n_inside_quotes;
    mtt_pkg::t_pos   n_run_start;
    mtt_pkg::t_pos   n_position;
    mtt_pkg::t_out   n_out_word;

    mtt_pkg::t_ctx    ctx;
    mtt_pkg::t_cls_res cls_res;
    mtt_pkg::t_pos    eff_run_start;
    mtt_pkg::t_pos    eff_position;
    mtt_pkg::t_pos    run_length;
    logic             accept;
    logic             class_change;
    logic             prev_word;
    logic             emit;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;

    always_comb begin
        if (i_in_word.start_of_text) begin
            ctx.inside_tag     = 1'b0;
            ctx.inside_quotes  = 1'b0;
            ctx.previous_class = mtt_pkg::CLS_NULL;
            eff_run_start      = '0;
            eff_position       = '0;
        end else begin
            ctx.inside_tag     = r_inside_tag;
            ctx.inside_quotes  = r_inside_quotes;
            ctx.previous_class = r_previous_class;
            eff_run_start      = r_run_start;
            eff_position       = r_position;
        end
    end

    mtt_classify u_classify (
        .i_ch  (i_in_word.ch),
        .i_ctx (ctx),
        .o_res (cls_res)
    );

    always_comb begin
        class_change = cls_res.cls != ctx.previous_class;
        prev_word    = ctx.previous_class == mtt_pkg::CLS_ALNUM ||
                       ctx.previous_class == mtt_pkg::CLS_PUNCT;
        emit         = class_change &&
                       (prev_word || (!ctx.inside_tag &&
                                      ctx.previous_class == mtt_pkg::CLS_SPACE));
        run_length   = eff_position - eff_run_start;

        n_out_word = '0;
        if (emit) begin
            n_out_word.token_valid  = 1'b1;
            if (ctx.inside_tag) begin
                n_out_word.token_kind = mtt_pkg::KIND_TAG;
            end else if (prev_word) begin
                n_out_word.token_kind = mtt_pkg::KIND_TEXT;
            end else begin
                n_out_word.token_kind = mtt_pkg::KIND_SPACE;
            end
            n_out_word.token_start  = 16'(eff_run_start);
            n_out_word.token_length = 16'(run_length);
        end
        n_out_word.tag_open  = cls_res.cls == mtt_pkg::CLS_TAG_BEGIN;
        n_out_word.tag_close = cls_res.cls == mtt_pkg::CLS_TAG_END;

        n_run_start     = class_change ? eff_position : eff_run_start;
        n_position      = eff_position + mtt_pkg::POSITION_BITS'(1);
        n_inside_quotes = cls_res.toggle_quotes ? !ctx.inside_quotes : ctx.inside_quotes;
        if (cls_res.cls == mtt_pkg::CLS_TAG_END) begin
            n_inside_tag = 1'b0;
        end else if (cls_res.cls == mtt_pkg::CLS_TAG_BEGIN) begin
            n_inside_tag = 1'b1;
        end else begin
            n_inside_tag = ctx.inside_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside_tag     <= 1'b0;
            r_inside_quotes  <= 1'b0;
            r_previous_class <= mtt_pkg::CLS_NULL;
            r_run_start      <= '0;
            r_position       <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (accept) begin
                r_inside_tag     <= n_inside_tag;
                r_inside_quotes  <= n_inside_quotes;
                r_previous_class <= cls_res.cls;
                r_run_start      <= n_run_start;
                r_position       <= n_position;
                r_out_valid      <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid      <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for markup_text_tokenizer: directed and random markup text
// against an in-bench model of the tokenizer. Depends on mtt_pkg and the RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mtt_pkg::*;

    localparam logic [15:0] CH_TAB   = 16'h0009;
    localparam logic [15:0] CH_CR    = 16'h000D;
    localparam logic [15:0] CH_SLASH = 16'h002F;
    localparam logic [15:0] CH_EQUAL = 16'h003D;
    localparam logic [15:0] CH_DEL   = 16'h007F;
    localparam logic [15:0] CH_HIGH  = 16'h0080;
    localparam logic [15:0] CH_MAX   = 16'hFFFF;

    localparam int RANDOM_CHARS   = 550;
    localparam int TAIL_CHARS     = 80;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int REPORT_LIMIT   = 200;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_ready;
    t_in   i_in_word;
    logic  o_out_valid;
    logic  i_out_ready;
    t_out  o_out_word;

    t_in   text_queue[$];
    t_out  expected_tokens[$];
    int    total_chars;
    int    chars_accepted;
    int    fail_count;
    int    quiet_cycles;
    int    in_gap;
    int    out_gap;
    bit    char_taken;

    logic   in_tag;
    logic   in_quotes;
    t_class prev_cls;
    t_pos   run_begin;
    t_pos   cur_pos;

    markup_text_tokenizer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_out tokenize_char(t_in w);
        t_class cls;
        t_out   r;
        t_pos   run_len;
        logic   letter_digit;
        logic   punct;
        logic   word_run;
        r = '0;
        cls = CLS_NULL;
        letter_digit = (w.ch >= 16'h0030 && w.ch <= 16'h0039) ||
                       (w.ch >= 16'h0041 && w.ch <= 16'h005A) ||
                       (w.ch >= 16'h0061 && w.ch <= 16'h007A);
        punct = (w.ch >= 16'd33 && w.ch <= 16'd47) || (w.ch >= 16'd58 && w.ch <= 16'd64) ||
                (w.ch >= 16'd91 && w.ch <= 16'd96) || (w.ch >= 16'd123 && w.ch <= 16'd126);
        if (w.start_of_text) begin
            in_tag = 1'b0;
            in_quotes = 1'b0;
            prev_cls = CLS_NULL;
            run_begin = '0;
            cur_pos = '0;
        end
        if (w.ch == CH_GT) begin
            cls = CLS_TAG_END;
        end else if (w.ch == CH_LT) begin
            cls = CLS_TAG_BEGIN;
        end else if (in_tag && w.ch == CH_QUOTE) begin
            in_quotes = !in_quotes;
        end else if (w.ch > 16'd127 || letter_digit) begin
            cls = CLS_ALNUM;
        end else if (punct) begin
            cls = in_tag ? CLS_PUNCT : CLS_ALNUM;
        end else if (w.ch == CH_SPACE) begin
            cls = in_quotes ? prev_cls : CLS_SPACE;
        end else if (w.ch == CH_NUL || w.ch == CH_LF) begin
            cls = CLS_EOL;
        end
        if (cls != prev_cls) begin
            word_run = (prev_cls == CLS_ALNUM) || (prev_cls == CLS_PUNCT);
            if (word_run || (!in_tag && prev_cls == CLS_SPACE)) begin
                run_len = cur_pos - run_begin;
                r.token_valid = 1'b1;
                r.token_kind = in_tag ? KIND_TAG : (word_run ? KIND_TEXT : KIND_SPACE);
                r.token_start = 16'(run_begin);
                r.token_length = 16'(run_len);
            end
            run_begin = cur_pos;
        end
        cur_pos = cur_pos + 1'b1;
        prev_cls = cls;
        if (cls == CLS_TAG_END) begin
            in_tag = 1'b0;
        end else if (cls == CLS_TAG_BEGIN) begin
            in_tag = 1'b1;
        end
        r.tag_open = (cls == CLS_TAG_BEGIN);
        r.tag_close = (cls == CLS_TAG_END);
        return r;
    endfunction

    task automatic put(logic [15:0] c, logic restart);
        t_in w;
        w.ch = c;
        w.start_of_text = restart;
        text_queue.push_back(w);
    endtask

    function automatic logic [15:0] text_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'($urandom_range(16'h0061, 16'h007A));
            4: return 16'($urandom_range(16'h0041, 16'h005A));
            5: return 16'($urandom_range(16'h0030, 16'h0039));
            6: return 16'($urandom_range(33, 47));
            7: return $urandom_range(0, 1) ? 16'($urandom_range(91, 96)) :
                                             16'($urandom_range(123, 126));
            default: return 16'($urandom_range(128, 65535));
        endcase
    endfunction

    task automatic add_word(int n);
        repeat (n) put(text_char(), 1'b0);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        logic in_fire;
        logic out_fire;
        t_out want;
        if (i_rst_n) begin
            in_fire = i_in_valid && o_in_ready;
            out_fire = o_out_valid && i_out_ready;
            if (in_fire) begin
                expected_tokens.push_back(tokenize_char(i_in_word));
                chars_accepted++;
                char_taken = 1'b1;
            end
            if (out_fire) begin
                if (expected_tokens.size() == 0) begin
                    fail_count++;
                    $error("result word with no expectation waiting");
                end else begin
                    want = expected_tokens.pop_front();
                    check_field("token_valid", want.token_valid, o_out_word.token_valid);
                    check_field("token_kind", want.token_kind, o_out_word.token_kind);
                    check_field("token_start", want.token_start, o_out_word.token_start);
                    check_field("token_length", want.token_length, o_out_word.token_length);
                    check_field("tag_open", want.tag_open, o_out_word.tag_open);
                    check_field("tag_close", want.tag_close, o_out_word.tag_close);
                end
            end
            if (in_fire || out_fire) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles == WATCHDOG_LIMIT) begin
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        bit stalls_on;
        if (i_rst_n) begin
            stalls_on = text_queue.size() > TAIL_CHARS;
            if (char_taken || !i_in_valid) begin
                char_taken = 1'b0;
                if (in_gap != 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (text_queue.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (stalls_on && $urandom_range(0, 9) == 0) begin
                    in_gap = $urandom_range(0, 14);
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in_word <= text_queue.pop_front();
                end
            end
            if (out_gap != 0) begin
                out_gap--;
                i_out_ready <= 1'b0;
            end else if (stalls_on && $urandom_range(0, 9) == 0) begin
                out_gap = $urandom_range(0, 14);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int random_goal;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_ready = 1'b0;
        chars_accepted = 0;
        fail_count = 0;
        quiet_cycles = 0;
        in_gap = 0;
        out_gap = 0;
        char_taken = 1'b0;
        in_tag = 1'b0;
        in_quotes = 1'b0;
        prev_cls = CLS_NULL;
        run_begin = '0;
        cur_pos = '0;

        // A quote left open when the tag closes keeps spaces from ending runs.
        put(CH_LT, 1'b1);
        put(16'h0070, 1'b0);
        put(CH_SPACE, 1'b0);
        put(16'h006B, 1'b0);
        put(CH_EQUAL, 1'b0);
        put(CH_QUOTE, 1'b0);
        put(16'h0076, 1'b0);
        put(CH_SPACE, 1'b0);
        put(16'h0077, 1'b0);
        put(CH_LT, 1'b0);
        put(CH_GT, 1'b0);
        put(CH_SPACE, 1'b0);
        put(CH_MAX, 1'b0);
        put(CH_HIGH, 1'b0);
        put(CH_QUOTE, 1'b0);
        put(CH_TAB, 1'b0);
        put(CH_DEL, 1'b0);
        put(CH_CR, 1'b0);
        put(CH_LF, 1'b0);
        put(CH_NUL, 1'b0);
        put(16'h007A, 1'b0);
        put(CH_SPACE, 1'b1);
        put(CH_SPACE, 1'b0);
        put(16'h0037, 1'b0);
        put(CH_NUL, 1'b0);

        random_goal = text_queue.size() + RANDOM_CHARS;
        while (text_queue.size() < random_goal) begin
            case ($urandom_range(0, 9))
                0, 1, 2: add_word($urandom_range(1, 8));
                3: repeat ($urandom_range(1, 3)) put(CH_SPACE, 1'b0);
                4, 5: begin
                    put(CH_LT, 1'b0);
                    if ($urandom_range(0, 2) == 0) put(CH_SLASH, 1'b0);
                    add_word($urandom_range(1, 5));
                    repeat ($urandom_range(0, 2)) begin
                        put(CH_SPACE, 1'b0);
                        add_word($urandom_range(1, 4));
                        put(CH_EQUAL, 1'b0);
                        put(CH_QUOTE, 1'b0);
                        repeat ($urandom_range(1, 6))
                            put($urandom_range(0, 3) == 0 ? CH_SPACE : text_char(), 1'b0);
                        put(CH_QUOTE, 1'b0);
                    end
                    put(CH_GT, 1'b0);
                end
                6: put($urandom_range(0, 1) ? CH_LF : CH_NUL, 1'b0);
                7: repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 1))
                        put(16'($urandom_range(0, 65535)), 1'b0);
                    else
                        put(16'($urandom_range(0, 31)), 1'b0);
                end
                8: case ($urandom_range(0, 2))
                    0: begin
                        put(CH_LT, 1'b0);
                        add_word($urandom_range(1, 4));
                    end
                    1: put(CH_GT, 1'b0);
                    default: put(CH_QUOTE, 1'b0);
                endcase
                default: put(text_char(), 1'b1);
            endcase
        end
        total_chars = text_queue.size();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (chars_accepted != total_chars || expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

FILE: files.f
hw/rtl/mtt_pkg.sv
hw/rtl/mtt_classify.sv
hw/rtl/markup_text_tokenizer.sv
tb/sv/testbench.sv
